FILE: hw/rtl/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

    // Shared unit operation codes
    localparam logic [1:0] OP_MUL        = 2'd0;
    localparam logic [1:0] OP_DIV        = 2'd1;
    localparam logic [1:0] OP_DIV_SCALED = 2'd2;

    // Step counts of the shared unit
    localparam int MUL_STEPS = 26;
    localparam int DIV_STEPS = 50;

    // Fixed-point constants
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [25:0] INV_TWO_PI_Q26  = 26'd10680707;
    localparam logic [19:0] AXLE_RESET      = 20'd19200;

    // Request to the shared multiply/divide unit
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] a;
        logic [25:0] b;
    } alu_req_t;

    // atan(2^-i) as a Q32 fraction of a turn
    function automatic logic [31:0] atan_q32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/diff_drive_odometry_step.sv
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         left_speed, right_speed, time_step (tdata)
// m_axis    out        pose_x, pose_y, pose_heading (tdata)
// cfg       in         wheel base (cfg_wdata, cfg_we)
//
// A request goes straight when the wheels match or when the turn rounds to
// nothing, and along an arc otherwise. Every step runs on the shared
// multiply/divide unit or on the CORDIC rotator (CORDIC_ITERATIONS = 16).
// Reset clears the pose and loads the default
// wheel base. s_tready is high only while idle; a full output register holds
// the finished pose and with it the input.
module diff_drive_odometry_step #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // left_speed, right_speed, time_step
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,  // pose_x, pose_y, pose_heading
    input  wire logic        cfg_we,
    input  wire logic [19:0] cfg_wdata
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_TURN_MUL1 = 4'd1;
    localparam logic [3:0] ST_TURN_MUL2 = 4'd2;
    localparam logic [3:0] ST_TURN_DIV  = 4'd3;
    localparam logic [3:0] ST_LIN_MUL   = 4'd4;
    localparam logic [3:0] ST_LIN_TRIG  = 4'd5;
    localparam logic [3:0] ST_LIN_X     = 4'd6;
    localparam logic [3:0] ST_LIN_Y     = 4'd7;
    localparam logic [3:0] ST_RAD_MUL   = 4'd8;
    localparam logic [3:0] ST_RAD_DIV   = 4'd9;
    localparam logic [3:0] ST_HALF_TRIG = 4'd10;
    localparam logic [3:0] ST_CHORD     = 4'd11;
    localparam logic [3:0] ST_MID_TRIG  = 4'd12;
    localparam logic [3:0] ST_ARC_X     = 4'd13;
    localparam logic [3:0] ST_ARC_Y     = 4'd14;
    localparam logic [3:0] ST_OUT       = 4'd15;

    logic [3:0]  state_reg, state_next;
    logic        issued_reg, issued_next;
    logic [19:0] axle_reg, axle_next;
    logic [19:0] left_reg, left_next;
    logic [19:0] right_reg, right_next;
    logic [15:0] dt_reg, dt_next;
    logic [31:0] pos_x_reg, pos_x_next;
    logic [31:0] pos_y_reg, pos_y_next;
    logic [15:0] heading_reg, heading_next;
    logic [32:0] dth_reg, dth_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [23:0] c_reg, c_next;
    logic [23:0] s_reg, s_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [79:0] m_tdata_reg, m_tdata_next;

    ddo_pkg::alu_req_t alu_req;
    logic              alu_start;
    logic              alu_done;
    logic [63:0]       alu_res;
    logic              trig_start;
    logic [31:0]       trig_angle;
    logic              trig_done;
    logic [23:0]       trig_cos;
    logic [23:0]       trig_sin;

    logic [20:0]        diff;
    logic [20:0]        sum;
    logic [19:0]        ax_eff;
    logic [31:0]        old_ang;
    logic [31:0]        new_ang;
    logic signed [63:0] res_s;
    logic signed [63:0] res_sh37;
    logic signed [63:0] res_sh20;

    function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [45:0] d);
        logic [45:0] t;
        logic [31:0] v;
        t = {{14{p[31]}}, p} + d;
        if (!t[45] && (|t[44:31])) begin
            v = 32'h7FFF_FFFF;
        end else if (t[45] && !(&t[44:31])) begin
            v = 32'h8000_0000;
        end else begin
            v = t[31:0];
        end
        return v;
    endfunction

    ddo_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .req     (alu_req),
        .done    (alu_done),
        .result  (alu_res)
    );

    ddo_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (trig_angle),
        .done    (trig_done),
        .cos_q20 (trig_cos),
        .sin_q20 (trig_sin)
    );

    // Operand forms shared by several steps
    assign diff     = {left_reg[19], left_reg} - {right_reg[19], right_reg};
    assign sum      = {left_reg[19], left_reg} + {right_reg[19], right_reg};
    assign ax_eff   = (axle_reg == 20'd0) ? 20'd1 : axle_reg;
    assign old_ang  = {heading_reg, 16'h0000};
    assign new_ang  = old_ang + dth_reg[31:0] + 32'h0000_8000;
    assign res_s    = signed'(alu_res);
    assign res_sh37 = res_s >>> 37;
    assign res_sh20 = res_s >>> 20;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        issued_next   = issued_reg;
        axle_next     = cfg_we ? cfg_wdata : axle_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        dt_next       = dt_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        heading_next  = heading_reg;
        dth_next      = dth_reg;
        tmp_next      = tmp_reg;
        c_next        = c_reg;
        s_next        = s_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        alu_start     = 1'b0;
        alu_req       = '{op: ddo_pkg::OP_MUL, a: 64'd0, b: 26'd0};
        trig_start    = 1'b0;
        trig_angle    = old_ang;

        case (state_reg)
            ST_IDLE: begin
                // Take a new request
                if (s_tvalid) begin
                    left_next  = s_tdata[19:0];
                    right_next = s_tdata[39:20];
                    dt_next    = s_tdata[55:40];
                    state_next = ST_TURN_MUL1;
                end
            end
            ST_TURN_MUL1: begin
                // diff * dt, or go straight when the wheels match
                alu_req = '{op: ddo_pkg::OP_MUL, a: {{43{diff[20]}}, diff},
                            b: {10'd0, dt_reg}};
                if (diff == 21'd0) begin
                    state_next = ST_LIN_MUL;
                end else begin
                    alu_start   = !issued_reg;
                    issued_next = 1'b1;
                    if (alu_done) begin
                        tmp_next    = alu_res;
                        issued_next = 1'b0;
                        state_next  = ST_TURN_MUL2;
                    end
                end
            end
            ST_TURN_MUL2: begin
                // Scale to turns
                alu_req     = '{op: ddo_pkg::OP_MUL, a: tmp_reg,
                                b: ddo_pkg::INV_TWO_PI_Q26};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    tmp_next    = alu_res;
                    issued_next = 1'b0;
                    state_next  = ST_TURN_DIV;
                end
            end
            ST_TURN_DIV: begin
                // Turn angle over axle * 1024
                alu_req     = '{op: ddo_pkg::OP_DIV_SCALED, a: tmp_reg,
                                b: {6'd0, ax_eff}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    dth_next    = alu_res[32:0];
                    issued_next = 1'b0;
                    state_next  = (alu_res == 64'd0) ? ST_LIN_MUL : ST_RAD_MUL;
                end
            end
            ST_LIN_MUL: begin
                // Distance sum * dt
                alu_req     = '{op: ddo_pkg::OP_MUL, a: {{43{sum[20]}}, sum},
                                b: {10'd0, dt_reg}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    tmp_next    = alu_res;
                    issued_next = 1'b0;
                    state_next  = ST_LIN_TRIG;
                end
            end
            ST_LIN_TRIG: begin
                trig_angle  = old_ang;
                trig_start  = !issued_reg;
                issued_next = 1'b1;
                if (trig_done) begin
                    c_next      = trig_cos;
                    s_next      = trig_sin;
                    issued_next = 1'b0;
                    state_next  = ST_LIN_X;
                end
            end
            ST_LIN_X: begin
                alu_req     = '{op: ddo_pkg::OP_MUL, a: tmp_reg,
                                b: {{2{c_reg[23]}}, c_reg}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    pos_x_next  = sat_add(pos_x_reg, res_sh37[45:0]);
                    issued_next = 1'b0;
                    state_next  = ST_LIN_Y;
                end
            end
            ST_LIN_Y: begin
                alu_req     = '{op: ddo_pkg::OP_MUL, a: tmp_reg,
                                b: {{2{s_reg[23]}}, s_reg}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    pos_y_next  = sat_add(pos_y_reg, res_sh37[45:0]);
                    issued_next = 1'b0;
                    state_next  = ST_OUT;
                end
            end
            ST_RAD_MUL: begin
                // axle * sum for the radius
                alu_req     = '{op: ddo_pkg::OP_MUL, a: {44'd0, ax_eff},
                                b: {{5{sum[20]}}, sum}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    tmp_next    = alu_res;
                    issued_next = 1'b0;
                    state_next  = ST_RAD_DIV;
                end
            end
            ST_RAD_DIV: begin
                alu_req     = '{op: ddo_pkg::OP_DIV, a: tmp_reg,
                                b: {{4{diff[20]}}, diff, 1'b0}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    tmp_next    = alu_res;
                    issued_next = 1'b0;
                    state_next  = ST_HALF_TRIG;
                end
            end
            ST_HALF_TRIG: begin
                trig_angle  = dth_reg[32:1];
                trig_start  = !issued_reg;
                issued_next = 1'b1;
                if (trig_done) begin
                    s_next      = trig_sin;
                    issued_next = 1'b0;
                    state_next  = ST_CHORD;
                end
            end
            ST_CHORD: begin
                // Chord 2 * R * sin(h)
                alu_req     = '{op: ddo_pkg::OP_MUL, a: {tmp_reg[62:0], 1'b0},
                                b: {{2{s_reg[23]}}, s_reg}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    tmp_next    = res_sh20;
                    issued_next = 1'b0;
                    state_next  = ST_MID_TRIG;
                end
            end
            ST_MID_TRIG: begin
                trig_angle  = old_ang + dth_reg[32:1];
                trig_start  = !issued_reg;
                issued_next = 1'b1;
                if (trig_done) begin
                    c_next      = trig_cos;
                    s_next      = trig_sin;
                    issued_next = 1'b0;
                    state_next  = ST_ARC_X;
                end
            end
            ST_ARC_X: begin
                alu_req     = '{op: ddo_pkg::OP_MUL, a: tmp_reg,
                                b: {{2{c_reg[23]}}, c_reg}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    pos_x_next  = sat_add(pos_x_reg, res_sh20[45:0]);
                    issued_next = 1'b0;
                    state_next  = ST_ARC_Y;
                end
            end
            ST_ARC_Y: begin
                // Last step of the arc also advances the heading
                alu_req     = '{op: ddo_pkg::OP_MUL, a: tmp_reg,
                                b: {{2{s_reg[23]}}, s_reg}};
                alu_start   = !issued_reg;
                issued_next = 1'b1;
                if (alu_done) begin
                    pos_y_next   = sat_add(pos_y_reg, res_sh20[45:0]);
                    heading_next = new_ang[31:16];
                    issued_next  = 1'b0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {heading_reg, pos_y_reg, pos_x_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issued_reg   <= 1'b0;
            axle_reg     <= ddo_pkg::AXLE_RESET;
            pos_x_reg    <= 32'd0;
            pos_y_reg    <= 32'd0;
            heading_reg  <= 16'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issued_reg   <= issued_next;
            axle_reg     <= axle_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            heading_reg  <= heading_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        left_reg    <= left_next;
        right_reg   <= right_next;
        dt_reg      <= dt_next;
        dth_reg     <= dth_next;
        tmp_reg     <= tmp_next;
        c_reg       <= c_next;
        s_reg       <= s_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ddo_alu.sv
`default_nettype none
module ddo_alu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire ddo_pkg::alu_req_t req,
    output logic                   done,
    output logic [63:0]            result
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_RUN  = 2'd1;
    localparam logic [1:0] U_FIX  = 2'd2;

    localparam logic [5:0] MUL_LAST = 6'(ddo_pkg::MUL_STEPS - 1);
    localparam logic [5:0] DIV_LAST = 6'(ddo_pkg::DIV_STEPS - 1);

    logic [1:0]  st_reg, st_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [25:0] mplier_reg, mplier_next;
    logic [49:0] dvd_reg, dvd_next;
    logic [20:0] dvs_reg, dvs_next;
    logic [20:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic        done_reg, done_next;

    logic [63:0] mag_a;
    logic [25:0] mag_b;
    logic [63:0] addend;
    logic [21:0] shifted;
    logic [22:0] trial;

    always_comb begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        div_next    = div_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        done_next   = 1'b0;

        mag_a   = req.a[63] ? (~req.a + 64'd1) : req.a;
        mag_b   = req.b[25] ? (~req.b + 26'd1) : req.b;
        addend  = mplier_reg[0] ? mcand_reg : 64'd0;
        shifted = {rem_reg, dvd_reg[49]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};

        case (st_reg)
            U_IDLE: begin
                // Load operands for the requested operation
                if (start) begin
                    st_next     = U_RUN;
                    cnt_next    = 6'd0;
                    acc_next    = 64'd0;
                    rem_next    = 21'd0;
                    mcand_next  = req.a;
                    mplier_next = req.b;
                    dvs_next    = mag_b[20:0];
                    case (req.op)
                        ddo_pkg::OP_MUL: begin
                            div_next = 1'b0;
                            neg_next = 1'b0;
                            dvd_next = mag_a[49:0];
                        end
                        ddo_pkg::OP_DIV_SCALED: begin
                            div_next = 1'b1;
                            neg_next = req.a[63] ^ req.b[25];
                            dvd_next = mag_a[59:10];
                        end
                        default: begin
                            div_next = 1'b1;
                            neg_next = req.a[63] ^ req.b[25];
                            dvd_next = mag_a[49:0];
                        end
                    endcase
                end
            end
            U_RUN: begin
                if (div_reg) begin
                    // One restoring quotient bit
                    dvd_next = {dvd_reg[48:0], 1'b0};
                    if (!trial[22]) begin
                        rem_next = trial[20:0];
                        acc_next = {acc_reg[62:0], 1'b1};
                    end else begin
                        rem_next = shifted[20:0];
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                end else begin
                    // One multiplier bit; the top bit weighs negative
                    acc_next    = (cnt_reg == MUL_LAST) ? (acc_reg - addend)
                                                        : (acc_reg + addend);
                    mcand_next  = {mcand_reg[62:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[25:1]};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == (div_reg ? DIV_LAST : MUL_LAST)) begin
                    st_next = U_FIX;
                end
            end
            U_FIX: begin
                // Apply quotient sign and hand over
                res_next  = neg_reg ? (~acc_reg + 64'd1) : acc_reg;
                done_next = 1'b1;
                st_next   = U_IDLE;
            end
            default: st_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= U_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        cnt_reg    <= cnt_next;
        div_reg    <= div_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ddo_cordic.sv
`default_nettype none
module ddo_cordic #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] angle,
    output logic             done,
    output logic [23:0]      cos_q20,
    output logic [23:0]      sin_q20
);

    localparam int IW = $clog2(CORDIC_ITERATIONS);
    localparam logic [IW-1:0] LAST = IW'(CORDIC_ITERATIONS - 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_FIX  = 2'd2;

    logic [1:0]        st_reg, st_next;
    logic [IW-1:0]     i_reg, i_next;
    logic              flip_reg, flip_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [23:0]       cos_reg, cos_next;
    logic [23:0]       sin_reg, sin_next;
    logic              done_reg, done_next;

    logic [31:0]        quad;
    logic [31:0]        folded;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [33:0] atan_v;
    logic signed [33:0] x_fin;
    logic signed [33:0] y_fin;

    always_comb begin
        st_next   = st_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        done_next = 1'b0;

        quad   = angle + 32'h4000_0000;
        folded = quad[31] ? (angle ^ 32'h8000_0000) : angle;
        x_sh   = x_reg >>> i_reg;
        y_sh   = y_reg >>> i_reg;
        atan_v = signed'({2'b00, ddo_pkg::atan_q32(5'(i_reg))});
        x_fin  = flip_reg ? -x_reg : x_reg;
        y_fin  = flip_reg ? -y_reg : y_reg;

        case (st_reg)
            C_IDLE: begin
                // Fold the angle into the right half plane
                if (start) begin
                    flip_next = quad[31];
                    x_next    = signed'({4'b0000, ddo_pkg::CORDIC_GAIN_Q30});
                    y_next    = '0;
                    z_next    = signed'({{2{folded[31]}}, folded});
                    i_next    = '0;
                    st_next   = C_RUN;
                end
            end
            C_RUN: begin
                // Rotate towards zero residual angle
                if (!z_reg[33]) begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_v;
                end else begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_v;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == LAST) begin
                    st_next = C_FIX;
                end
            end
            C_FIX: begin
                // Undo the fold and drop to Q20
                cos_next  = x_fin[33:10];
                sin_next  = y_fin[33:10];
                done_next = 1'b1;
                st_next   = C_IDLE;
            end
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= C_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        i_reg    <= i_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign done    = done_reg;
    assign cos_q20 = cos_reg;
    assign sin_q20 = sin_reg;

endmodule
`default_nettype wire
